/* sv/sha1_word_stream_hasher_assert.svh */
// Assertion macros shared by the SHA-1 word stream hasher.
`ifndef SHA1_WORD_STREAM_HASHER_ASSERT_SVH
`define SHA1_WORD_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SHA1WS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SHA1WS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sha1ws_pkg.sv */
// Shared types, constants and helpers of the SHA-1 word stream hasher.
package sha1ws_pkg;

    localparam int unsigned WordW       = 32;
    localparam int unsigned NumWords    = 16;
    localparam int unsigned DigestWords = 5;
    localparam int unsigned CntW        = 4;
    localparam int unsigned RndW        = 7;
    localparam int unsigned QDepth      = 2;
    localparam int unsigned QLevelW     = 2;

    typedef logic [WordW-1:0] word_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hEFCDAB89;
    localparam word_t H2 = 32'h98BADCFE;
    localparam word_t H3 = 32'h10325476;
    localparam word_t H4 = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam word_t PAD_MARK = 32'h80000000;

    localparam logic [RndW-1:0] ROUND_LAST = 7'd79;

    // One queued beat after classification.
    typedef struct packed {
        logic  is_end;
        word_t word;
    } item_t;

    // Status of the compression engine, watched by the top level.
    typedef struct packed {
        logic            in_rounds;
        logic            in_add;
        logic [RndW-1:0] round;
    } back_status_t;

    function automatic word_t rotl1(input word_t x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

endpackage

/* sv/sha1_word_stream_hasher.sv */
// SHA-1 word stream hasher: streaming input queue, compression engine, digest output.
// Input channel s_*: one beat per 32-bit message word (s_tuser = 0, first byte in
// bits 31..24), or an end beat (s_tuser = 1, s_tdata ignored) that closes the message.
// Output channel m_*: one beat per end beat, the 160-bit digest with digest_0 in the
// low 32 bits of m_tdata. The next message starts from the initial hash at once.
// A two-entry queue sits between the input and the engine, so beats keep flowing
// while the engine compresses until the queue fills and s_tready drops.
// Timing is set by the single round unit, one SHA-1 round per cycle:
//   data word: written into the block by the idle engine; the 16th word of a block
//   starts the 80 rounds, then the chain addition.
//   end beat: the padded block runs 80 rounds and the chain addition into the digest
//   register, after an extra padding block when the tail holds 14 or 15 words.
// Reset clears the queue and the output, loads the initial hash and a zero length.
// When the receiver stalls, the digest is held in the output register; a second
// digest waits in the engine's final step, then the queue and s_tready back up.
module sha1_word_stream_hasher
    import sha1ws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,     // word
    input  logic         s_tuser,     // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata      // digest_0, digest_1, digest_2, digest_3, digest_4
);

`include "sha1_word_stream_hasher_assert.svh"

    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic [QLevelW-1:0] level;
    back_status_t       back_st;

    sha1ws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .level      (level)
    );

    sha1ws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .status     (back_st)
    );

    `SHA1WS_ASSERT_IMP(a_digest_after_add, $rose(m_tvalid), $past(back_st.in_add),
        "digest appeared without a chain addition step")
    `SHA1WS_ASSERT_IMP(a_rounds_start_zero, $rose(back_st.in_rounds), back_st.round == '0,
        "compression started at a nonzero round")
    `SHA1WS_ASSERT_IMP(a_add_after_last, back_st.in_add && !$past(back_st.in_add),
        $past(back_st.round) == ROUND_LAST, "chain addition before the last round")
    `SHA1WS_ASSERT_NXT(a_queue_push, s_tvalid && s_tready && !(item_valid && item_ready),
        level == $past(level) + QLevelW'(1), "queued beat lost")

endmodule

/* sv/sha1ws_front.sv */
// Input side: accepts beats, classifies them and queues them for the engine.
module sha1ws_front
    import sha1ws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,     // word
    input  logic               s_tuser,     // kind
    output logic               item_valid,
    input  logic               item_ready,
    output item_t              item,
    output logic [QLevelW-1:0] level
);

    item_t              slot_reg [QDepth];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [QLevelW-1:0] count_reg;
    logic               push;
    logic               pop;
    item_t              incoming;

    assign s_tready   = (count_reg != QLevelW'(QDepth));
    assign item_valid = (count_reg != '0);
    assign item       = slot_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        incoming.is_end = (s_tuser == KIND_END);
        incoming.word   = s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + QLevelW'(1);
            else if (pop && !push)
                count_reg <= count_reg - QLevelW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= incoming;
    end

endmodule

/* sv/sha1ws_back.sv */
// Compression engine: block loading, padding, 80 rounds and the digest register.
module sha1ws_back
    import sha1ws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  item_t        item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,     // digest_0, digest_1, digest_2, digest_3, digest_4
    output back_status_t status
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD} state_t;
    typedef enum logic [1:0] {MODE_DATA, MODE_PAD, MODE_LAST} mode_t;

    state_t          state_reg,  state_next;
    mode_t           mode_reg,   mode_next;
    logic [RndW-1:0] rnd_reg,    rnd_next;
    logic [CntW-1:0] cnt_reg,    cnt_next;
    word_t           bits_reg,   bits_next;
    word_t           chain_reg   [DigestWords];
    word_t           chain_next  [DigestWords];
    word_t           rv_reg      [DigestWords];
    word_t           rv_next     [DigestWords];
    word_t           out_reg     [DigestWords];
    word_t           out_next    [DigestWords];
    logic            out_vld_reg, out_vld_next;
    word_t           win_reg     [NumWords];
    word_t           win_next    [NumWords];

    word_t           f_val;
    word_t           k_val;
    word_t           round_sum;
    word_t           w_new;
    word_t           added       [DigestWords];
    logic            out_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = {out_reg[4], out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign out_free   = !out_vld_reg || m_tready;

    assign status.in_rounds = (state_reg == ST_ROUND);
    assign status.in_add    = (state_reg == ST_ADD);
    assign status.round     = rnd_reg;

    // Round function and constant by round group.
    always_comb
    begin
        priority if (rnd_reg < 7'd20)
        begin
            f_val = (rv_reg[1] & rv_reg[2]) | (~rv_reg[1] & rv_reg[3]);
            k_val = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = rv_reg[1] ^ rv_reg[2] ^ rv_reg[3];
            k_val = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (rv_reg[1] & rv_reg[2]) | (rv_reg[1] & rv_reg[3])
                  | (rv_reg[2] & rv_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = rv_reg[1] ^ rv_reg[2] ^ rv_reg[3];
            k_val = K3;
        end
    end

    // Window slot 0 holds the schedule word of the current round.
    assign round_sum = rotl5(rv_reg[0]) + f_val + rv_reg[4] + k_val + win_reg[0];
    assign w_new     = rotl1(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);

    always_comb
    begin
        for (int q = 0; q < DigestWords; q++)
            added[q] = chain_reg[q] + rv_reg[q];
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        rnd_next     = rnd_reg;
        cnt_next     = cnt_reg;
        bits_next    = bits_reg;
        chain_next   = chain_reg;
        rv_next      = rv_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_tready;
        win_next     = win_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!item.is_end)
                    begin
                        win_next[cnt_reg] = item.word;
                        cnt_next          = cnt_reg + CntW'(1);
                        bits_next         = bits_reg + 32'd32;
                        if (cnt_reg == CntW'(NumWords - 1))
                        begin
                            rv_next    = chain_reg;
                            rnd_next   = '0;
                            mode_next  = MODE_DATA;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        // Marker after the data, zeros to the end of the block.
                        for (int q = 0; q < NumWords; q++)
                        begin
                            if (CntW'(q) == cnt_reg)
                                win_next[q] = PAD_MARK;
                            else if (CntW'(q) > cnt_reg)
                                win_next[q] = '0;
                        end
                        // Length fits in this block unless the tail is 14 or 15 words.
                        if (cnt_reg < CntW'(NumWords - 2))
                        begin
                            win_next[NumWords-1] = bits_reg;
                            mode_next            = MODE_LAST;
                        end
                        else
                        begin
                            mode_next = MODE_PAD;
                        end
                        rv_next    = chain_reg;
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                end
            end

            ST_ROUND:
            begin
                rv_next[0] = round_sum;
                rv_next[1] = rv_reg[0];
                rv_next[2] = rotl30(rv_reg[1]);
                rv_next[3] = rv_reg[2];
                rv_next[4] = rv_reg[3];
                for (int q = 0; q < NumWords - 1; q++)
                    win_next[q] = win_reg[q+1];
                win_next[NumWords-1] = w_new;
                rnd_next = rnd_reg + RndW'(1);
                if (rnd_reg == ROUND_LAST)
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                unique case (mode_reg)
                    MODE_DATA:
                    begin
                        chain_next = added;
                        state_next = ST_IDLE;
                    end
                    MODE_PAD:
                    begin
                        // Extra block: zeros with the length in the last word.
                        chain_next = added;
                        rv_next    = added;
                        for (int q = 0; q < NumWords - 1; q++)
                            win_next[q] = '0;
                        win_next[NumWords-1] = bits_reg;
                        rnd_next   = '0;
                        mode_next  = MODE_LAST;
                        state_next = ST_ROUND;
                    end
                    MODE_LAST:
                    begin
                        // Hold here while the previous digest is still waiting.
                        if (out_free)
                        begin
                            out_next      = added;
                            out_vld_next  = 1'b1;
                            chain_next[0] = H0;
                            chain_next[1] = H1;
                            chain_next[2] = H2;
                            chain_next[3] = H3;
                            chain_next[4] = H4;
                            cnt_next      = '0;
                            bits_next     = '0;
                            state_next    = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_DATA;
            rnd_reg      <= '0;
            cnt_reg      <= '0;
            bits_reg     <= '0;
            chain_reg[0] <= H0;
            chain_reg[1] <= H1;
            chain_reg[2] <= H2;
            chain_reg[3] <= H3;
            chain_reg[4] <= H4;
            for (int q = 0; q < DigestWords; q++)
            begin
                rv_reg[q]  <= '0;
                out_reg[q] <= '0;
            end
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            rnd_reg     <= rnd_next;
            cnt_reg     <= cnt_next;
            bits_reg    <= bits_next;
            chain_reg   <= chain_next;
            rv_reg      <= rv_next;
            out_reg     <= out_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

/* tb/sha1_digest_checker.sv */
// Digest predictor and checker that watches both streams of the SHA-1 word stream hasher.
module sha1_digest_checker
    import sha1ws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    output int           mismatches,
    output int           digests_pending
);

    word_t          hash_state [DigestWords];
    word_t          sched      [NumWords];
    logic [3:0]     fill;
    logic [31:0]    bit_len;
    logic [159:0]   expected_digests [$];
    int             digests_seen;

    function automatic word_t rol(input word_t x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void start_message();
        hash_state[0] = H0;
        hash_state[1] = H1;
        hash_state[2] = H2;
        hash_state[3] = H3;
        hash_state[4] = H4;
        fill          = '0;
        bit_len       = '0;
    endfunction

    // Run the 80 rounds over sched and fold the result into the chain.
    function automatic void compress_block();
        word_t a, b, c, d, e, f, k, w, t;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                w = sched[(r + 13) % 16] ^ sched[(r + 8) % 16]
                  ^ sched[(r + 2) % 16] ^ sched[r % 16];
                sched[r % 16] = rol(w, 1);
            end
            w = sched[r % 16];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rol(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void append_word(input word_t data);
        sched[fill] = data;
        bit_len     = bit_len + 32'd32;
        fill        = fill + 4'd1;
        if (fill == 4'd0)
        begin
            compress_block();
        end
    endfunction

    function automatic logic [159:0] close_message();
        int           n;
        logic [159:0] digest;
        n = int'(fill);
        sched[n] = PAD_MARK;
        for (int q = n + 1; q < 16; q++)
        begin
            sched[q] = '0;
        end
        // Marker leaves no room for the length: spill into an extra block.
        if (n >= 14)
        begin
            compress_block();
            foreach (sched[q])
            begin
                sched[q] = '0;
            end
        end
        sched[14] = '0;
        sched[15] = bit_len;
        compress_block();
        digest = {hash_state[4], hash_state[3], hash_state[2], hash_state[1], hash_state[0]};
        start_message();
        return digest;
    endfunction

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("digest %0d: %s got %08h expected %08h", idx, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches      = 0;
        digests_pending = 0;
        digests_seen    = 0;
        start_message();
        foreach (sched[i])
        begin
            sched[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        logic [159:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == KIND_END)
                begin
                    expected_digests.push_back(close_message());
                end
                else
                begin
                    append_word(s_tdata);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_digests.size() == 0)
                begin
                    report_mismatch("unexpected beat, digest_0", digests_seen,
                                    m_tdata[31:0], 32'h0000_0000);
                end
                else
                begin
                    want = expected_digests.pop_front();
                    for (int i = 0; i < DigestWords; i++)
                    begin
                        if (m_tdata[32*i +: 32] !== want[32*i +: 32])
                        begin
                            report_mismatch($sformatf("digest_%0d", i), digests_seen,
                                            m_tdata[32*i +: 32], want[32*i +: 32]);
                        end
                    end
                end
                digests_seen++;
            end
            digests_pending = expected_digests.size();
        end
    end

endmodule

/* tb/tb_sha1_word_stream_hasher.sv */
// Stimulus, clocking and verdict for the SHA-1 word stream hasher.
module tb_sha1_word_stream_hasher;
    import sha1ws_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int RandomWords = 1400;
    localparam int DrainCycles = 400;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic         s_tuser  = KIND_DATA;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;

    int mismatches;
    int digests_pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int words_sent  = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    sha1_word_stream_hasher i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sha1_digest_checker i_digest_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .digests_pending (digests_pending)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("sha1_word_stream_hasher test failed");
            $finish;
        end
    end

    // Receiver: switch between always ready, coin-flip and long stalls.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send_beat(input logic kind, input logic [31:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (kind == KIND_DATA)
        begin
            words_sent++;
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_beat(KIND_DATA, pick_word());
        end
        send_beat(KIND_END, $urandom);
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            case ($urandom_range(0, 8))
                0:       return 13;
                1:       return 14;
                2:       return 15;
                3:       return 16;
                4:       return 17;
                5:       return 30;
                6:       return 31;
                7:       return 32;
                default: return 46;
            endcase
        end
        else if (sel < 88)
        begin
            return $urandom_range(0, 20);
        end
        else if (sel < 97)
        begin
            return $urandom_range(33, 60);
        end
        return $urandom_range(61, 100);
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty message, single extreme words, then a 15-word tail with extremes.
        send_beat(KIND_END, 32'hFFFF_FFFF);
        send_beat(KIND_DATA, 32'h0000_0000);
        send_beat(KIND_END, 32'h0000_0000);
        send_beat(KIND_DATA, 32'hFFFF_FFFF);
        send_beat(KIND_END, 32'h8000_0000);
        for (int i = 0; i < 15; i++)
        begin
            send_beat(KIND_DATA, (i % 3 == 0) ? 32'hFFFF_FFFF :
                                 (i % 3 == 1) ? 32'h0000_0000 : $urandom);
        end
        send_beat(KIND_END, 32'h0000_0001);

        words_sent = 0;
        while (words_sent < RandomWords)
        begin
            send_message(pick_length());
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every digest, then watch for stray beats.
        @(posedge clk);
        while (digests_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("sha1_word_stream_hasher test passed");
        end
        else
        begin
            $display("sha1_word_stream_hasher test failed");
        end
        $finish;
    end

endmodule
